FILE: hdl/kcs_pkg.sv
package kcs_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 16;
  localparam int NUM_CAT           = 12;
  localparam int NUM_KEYWORDS      = 51;
  localparam int KW_MAX_LEN        = 11;
  localparam int CAT_W             = 4;
  localparam int SCORE_W           = 4;
  localparam int KW_LEN_W          = 4;

  localparam logic [SCORE_W-1:0] STEP_TENTHS = 4'd4;
  localparam logic [SCORE_W-1:0] FULL_TENTHS = 4'd10;

  // item kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EMIT = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    logic [CAT_W-1:0]   category;
    logic [SCORE_W-1:0] score_tenths;
    logic               touched;
    logic               last;
  } result_t;

  // token end event from the token builder
  typedef struct packed {
    logic end_tok;
    logic emit;
  } tok_evt_t;

  // registered match outcome
  typedef struct packed {
    logic [NUM_CAT-1:0] hit;
    logic               emit;
  } match_t;

  // keyword text is right aligned: first char in the highest used byte
  typedef struct packed {
    logic [8*KW_MAX_LEN-1:0] text;
    logic [KW_LEN_W-1:0]     len;
    logic [CAT_W-1:0]        cat;
  } kw_entry_t;

  localparam kw_entry_t KW_TABLE [NUM_KEYWORDS] = '{
    '{"login", 4'd5, 4'd0}, '{"password", 4'd8, 4'd0}, '{"passwd", 4'd6, 4'd0},
    '{"auth", 4'd4, 4'd0}, '{"token", 4'd5, 4'd0}, '{"session", 4'd7, 4'd0},
    '{"jwt", 4'd3, 4'd0}, '{"credential", 4'd10, 4'd0}, '{"oauth", 4'd5, 4'd0},
    '{"upload", 4'd6, 4'd1}, '{"download", 4'd8, 4'd1}, '{"file", 4'd4, 4'd1},
    '{"path", 4'd4, 4'd1}, '{"filename", 4'd8, 4'd1}, '{"directory", 4'd9, 4'd1},
    '{"exec", 4'd4, 4'd2}, '{"shell", 4'd5, 4'd2}, '{"command", 4'd7, 4'd2},
    '{"subprocess", 4'd10, 4'd2}, '{"spawn", 4'd5, 4'd2},
    '{"sql", 4'd3, 4'd3}, '{"query", 4'd5, 4'd3}, '{"database", 4'd8, 4'd3},
    '{"orm", 4'd3, 4'd3},
    '{"serialize", 4'd9, 4'd4}, '{"deserialize", 4'd11, 4'd4},
    '{"pickle", 4'd6, 4'd4}, '{"yaml", 4'd4, 4'd4},
    '{"url", 4'd3, 4'd5}, '{"fetch", 4'd5, 4'd5}, '{"webhook", 4'd7, 4'd5},
    '{"proxy", 4'd5, 4'd5}, '{"request", 4'd7, 4'd5},
    '{"eval", 4'd4, 4'd6}, '{"template", 4'd8, 4'd6},
    '{"render", 4'd6, 4'd7}, '{"html", 4'd4, 4'd7}, '{"dom", 4'd3, 4'd7},
    '{"crypto", 4'd6, 4'd8}, '{"encrypt", 4'd7, 4'd8}, '{"hash", 4'd4, 4'd8},
    '{"cipher", 4'd6, 4'd8}, '{"random", 4'd6, 4'd8},
    '{"buffer", 4'd6, 4'd9}, '{"memcpy", 4'd6, 4'd9}, '{"pointer", 4'd7, 4'd9},
    '{"malloc", 4'd6, 4'd9},
    '{"regex", 4'd5, 4'd10},
    '{"secret", 4'd6, 4'd11}, '{"apikey", 4'd6, 4'd11}, '{"key", 4'd3, 4'd11}
  };

endpackage

FILE: hdl/keyword_category_scorer.sv
// keyword category scorer: text arrives one byte per beat; letters and digits
// build a lower-cased token, any other byte or an end-of-text beat closes it,
// and a closed token is matched against all 51 keywords at once, adding four
// tenths (saturating at ten) to its category. text bytes and end-of-text
// beats are taken every cycle outside an emit. an emit beat closes the last
// token, then the input stalls while the twelve category results go out one
// per cycle from the output register, as long as the result side does not
// stall. pipeline: token buffer -> registered category hit vector -> score
// registers and result sequencer.
module keyword_category_scorer #(
  parameter int MAX_TOKEN_LEN = kcs_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  kcs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output kcs_pkg::result_t result
);
  import kcs_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  logic                          take;
  logic [MAX_TOKEN_LEN-1:0][7:0] chars;
  logic [LEN_W-1:0]              length;
  logic                          overflow;
  tok_evt_t                      evt;
  match_t                        match;
  logic                          busy;

  // hold input while an emit is in flight or results are still draining
  assign item_stall = busy || match.emit;
  assign take       = item_valid && !item_stall;

  // token buffer, case folding and token end detection
  kcs_token #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_token (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .chars    (chars),
    .length   (length),
    .overflow (overflow),
    .evt      (evt)
  );

  // parallel keyword compare, registered per-category hits
  kcs_match #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_match (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .length   (length),
    .overflow (overflow),
    .evt      (evt),
    .match    (match)
  );

  // saturating scores, snapshot on emit, one result beat per cycle unless the receiver stalls
  kcs_profile u_profile (
    .clk          (clk),
    .rst          (rst),
    .match        (match),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .busy         (busy)
  );

endmodule

FILE: hdl/kcs_token.sv
module kcs_token #(
  parameter int MAX_TOKEN_LEN = kcs_pkg::MAX_TOKEN_LEN_DEF,
  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1),
  localparam int IDX_W = $clog2(MAX_TOKEN_LEN)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  kcs_pkg::item_t                item,
  output logic [MAX_TOKEN_LEN-1:0][7:0] chars,
  output logic [LEN_W-1:0]              length,
  output logic                          overflow,
  output kcs_pkg::tok_evt_t             evt
);
  import kcs_pkg::*;

  logic       is_upper;
  logic       is_alnum;
  logic [7:0] ch;
  logic       room;

  assign is_upper = (item.text_byte >= "A") && (item.text_byte <= "Z");
  assign is_alnum = is_upper
                 || ((item.text_byte >= "a") && (item.text_byte <= "z"))
                 || ((item.text_byte >= "0") && (item.text_byte <= "9"));
  assign ch       = is_upper ? item.text_byte + 8'd32 : item.text_byte;
  assign room     = length < LEN_W'(MAX_TOKEN_LEN);

  always_comb begin
    evt.end_tok = take && ((item.kind == KIND_END) || (item.kind == KIND_EMIT)
                        || ((item.kind == KIND_BYTE) && !is_alnum));
    evt.emit    = take && (item.kind == KIND_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      overflow <= 1'b0;
    end else if (evt.end_tok) begin
      length   <= '0;
      overflow <= 1'b0;
    end else if (take && item.kind == KIND_BYTE) begin
      if (room) begin
        length <= length + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.kind == KIND_BYTE && is_alnum && room) begin
      chars[length[IDX_W-1:0]] <= ch;
    end
  end

endmodule

FILE: hdl/kcs_match.sv
module kcs_match #(
  parameter int MAX_TOKEN_LEN = kcs_pkg::MAX_TOKEN_LEN_DEF,
  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [MAX_TOKEN_LEN-1:0][7:0] chars,
  input  logic [LEN_W-1:0]              length,
  input  logic                          overflow,
  input  kcs_pkg::tok_evt_t             evt,
  output kcs_pkg::match_t               match
);
  import kcs_pkg::*;

  logic [NUM_KEYWORDS-1:0] kw_hit;
  logic [NUM_CAT-1:0]      cat_hit;

  // every keyword compared in parallel against the held token
  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      kw_hit[k] = (length == LEN_W'(KW_TABLE[k].len));
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < int'(KW_TABLE[k].len)) begin
          if (chars[i] != KW_TABLE[k].text[(int'(KW_TABLE[k].len) - 1 - i) * 8 +: 8]) begin
            kw_hit[k] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    cat_hit = '0;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (kw_hit[k]) begin
        cat_hit[KW_TABLE[k].cat] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= '0;
    end else begin
      match.hit  <= (evt.end_tok && !overflow) ? cat_hit : '0;
      match.emit <= evt.emit;
    end
  end

endmodule

FILE: hdl/kcs_profile.sv
module kcs_profile (
  input  logic             clk,
  input  logic             rst,
  input  kcs_pkg::match_t  match,
  input  logic             result_stall,
  output logic             result_valid,
  output kcs_pkg::result_t result,
  output logic             busy
);
  import kcs_pkg::*;

  logic [SCORE_W-1:0] score      [NUM_CAT];
  logic [SCORE_W-1:0] score_next [NUM_CAT];
  logic [NUM_CAT-1:0] touched;
  logic [NUM_CAT-1:0] touched_next;
  logic [SCORE_W-1:0] snap_score [NUM_CAT];
  logic [NUM_CAT-1:0] snap_touched;
  logic [CAT_W-1:0]   cnt;
  logic               advance;
  logic [SCORE_W:0]   sum [NUM_CAT];

  // add one step per hit, saturating at full
  always_comb begin
    for (int c = 0; c < NUM_CAT; c++) begin
      sum[c] = {1'b0, score[c]} + {1'b0, STEP_TENTHS};
      if (!match.hit[c]) begin
        score_next[c] = score[c];
      end else if (sum[c] > {1'b0, FULL_TENTHS}) begin
        score_next[c] = FULL_TENTHS;
      end else begin
        score_next[c] = sum[c][SCORE_W-1:0];
      end
    end
    touched_next = touched | match.hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CAT; c++) begin
        score[c] <= '0;
      end
      touched <= '0;
    end else begin
      for (int c = 0; c < NUM_CAT; c++) begin
        score[c] <= match.emit ? '0 : score_next[c];
      end
      touched <= match.emit ? '0 : touched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (match.emit) begin
      snap_score   <= score_next;
      snap_touched <= touched_next;
    end
  end

  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        result_valid <= busy;
        if (busy) begin
          result.category     <= cnt;
          result.score_tenths <= snap_score[cnt];
          result.touched      <= snap_touched[cnt];
          result.last         <= (cnt == CAT_W'(NUM_CAT - 1));
          cnt                 <= cnt + 1'b1;
          if (cnt == CAT_W'(NUM_CAT - 1)) begin
            busy <= 1'b0;
          end
        end
      end
      if (match.emit) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import kcs_pkg::*;

  // ignored item kind, has no name in the package
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  localparam int WORD_SLOTS = 16;   // token buffer depth of the default build
  localparam int CATS       = 12;
  localparam int WORDS      = 51;
  localparam logic [3:0] HIT_STEP  = 4'd4;
  localparam logic [3:0] SCORE_CAP = 4'd10;

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  keyword_category_scorer uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // keyword list and the category each word feeds
  string kw_word [WORDS] = '{
    "login", "password", "passwd", "auth", "token", "session", "jwt", "credential", "oauth",
    "upload", "download", "file", "path", "filename", "directory",
    "exec", "shell", "command", "subprocess", "spawn",
    "sql", "query", "database", "orm",
    "serialize", "deserialize", "pickle", "yaml",
    "url", "fetch", "webhook", "proxy", "request",
    "eval", "template",
    "render", "html", "dom",
    "crypto", "encrypt", "hash", "cipher", "random",
    "buffer", "memcpy", "pointer", "malloc",
    "regex",
    "secret", "apikey", "key"
  };
  int kw_cat [WORDS] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0,
    1, 1, 1, 1, 1, 1,
    2, 2, 2, 2, 2,
    3, 3, 3, 3,
    4, 4, 4, 4,
    5, 5, 5, 5, 5,
    6, 6,
    7, 7, 7,
    8, 8, 8, 8, 8,
    9, 9, 9, 9,
    10,
    11, 11, 11
  };

  // directed script: text sent byte by byte, then one closing beat.
  // hand-written expectations hold one score nibble per category, category 0 lowest
  typedef struct {
    string       text;
    logic [1:0]  close_kind;
    logic [7:0]  close_byte;
    bit          typed;
    logic [47:0] typed_score;
    logic [11:0] typed_hit;
  } script_row_t;

  script_row_t script [20] = '{
    // emit straight out of reset: empty profile
    '{"", KIND_EMIT, 8'h00, 1'b1, 48'h0, 12'h0},
    // upper case folds to lower case
    '{"LOGIN password", KIND_END, 8'h00, 1'b0, 48'h0, 12'h0},
    // third, fourth and fifth hits saturate, zero byte closes a token
    '{"jwt Auth  TOKEN", KIND_BYTE, 8'h00, 1'b0, 48'h0, 12'h0},
    // emit closes the pending token first
    '{"key secret APIKEY", KIND_EMIT, 8'hff, 1'b1, 48'hA000_0000_000A, 12'h801},
    // separators right outside the letter and digit ranges
    '{"exec@shell[sql{orm/url:eval dom", KIND_BYTE, 8'hff, 1'b0, 48'h0, 12'h0},
    // full buffer, no keyword that long
    '{"passwordpassword", KIND_BYTE, 8'h60, 1'b0, 48'h0, 12'h0},
    // overflowed token never matches
    '{"credentialcredentialcredential", KIND_END, 8'h00, 1'b0, 48'h0, 12'h0},
    // overflow flag clears at token end, high-bit byte is a separator
    '{"aaaaaaaaaaaaaaaaaaaaaaaa hash", KIND_BYTE, 8'hc1, 1'b0, 48'h0, 12'h0},
    // near misses and the longest keyword
    '{"keys ke deserializer DESERIALIZE", KIND_END, 8'h00, 1'b0, 48'h0, 12'h0},
    // end of text splits a token
    '{"pass", KIND_END, 8'h00, 1'b0, 48'h0, 12'h0},
    '{"word", KIND_BYTE, 8'h80, 1'b0, 48'h0, 12'h0},
    // ignored kind in mid token leaves the token intact
    '{"jw", KIND_IGNORED, 8'h74, 1'b0, 48'h0, 12'h0},
    '{"t", KIND_END, 8'h00, 1'b0, 48'h0, 12'h0},
    '{"0123456789 AZaz09 regex9 Regex", KIND_EMIT, 8'h00, 1'b0, 48'h0, 12'h0},
    '{"buffer memcpy pointer malloc", KIND_END, 8'h00, 1'b0, 48'h0, 12'h0},
    '{"render html template fetch webhook proxy request", KIND_BYTE, 8'h20,
      1'b0, 48'h0, 12'h0},
    '{"crypto encrypt hash cipher random", KIND_END, 8'h00, 1'b0, 48'h0, 12'h0},
    '{"serialize pickle yaml upload download file path filename directory", KIND_END,
      8'h00, 1'b0, 48'h0, 12'h0},
    '{"command subprocess spawn query database oauth session passwd credential",
      KIND_EMIT, 8'h00, 1'b0, 48'h0, 12'h0},
    // profile was cleared by the previous emit
    '{"", KIND_EMIT, 8'h5a, 1'b1, 48'h0, 12'h0}
  };

  // scorer state as the testbench sees it
  logic [7:0] word_buf [WORD_SLOTS];
  int         word_len  = 0;
  bit         word_long = 1'b0;
  logic [3:0] cat_score [CATS];
  bit         cat_hit   [CATS];

  result_t due_results [$];   // category results still to come out
  int      mismatches = 0;
  int      fed        = 0;    // accepted item beats, ignored kind excluded
  int      gap_pct    = 9;    // sender idle chance per cycle
  int      stall_pct  = 85;   // receiver stall chance per cycle

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit is_word_char(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9");
  endfunction

  // append one expected result beat at the tail
  function automatic void queue_result(result_t r);
    due_results = {due_results, r};
  endfunction

  // closing a token scores every keyword it equals
  task automatic close_word();
    bit         same;
    logic [4:0] sum;
    if (word_len != 0 && !word_long) begin
      for (int k = 0; k < WORDS; k++) begin
        same = (kw_word[k].len() == word_len);
        for (int i = 0; same && i < word_len; i++)
          if (word_buf[i] != kw_word[k][i]) same = 1'b0;
        if (same) begin
          sum = {1'b0, cat_score[kw_cat[k]]} + HIT_STEP;
          cat_score[kw_cat[k]] = (sum > SCORE_CAP) ? SCORE_CAP : sum[3:0];
          cat_hit[kw_cat[k]]   = 1'b1;
        end
      end
    end
    word_len  = 0;
    word_long = 1'b0;
  endtask

  // advance the expected profile by one accepted beat
  task automatic track_beat(item_t it);
    result_t    r;
    logic [7:0] ch;
    case (it.kind)
      KIND_BYTE: begin
        if (!is_word_char(it.text_byte)) begin
          close_word();
        end else begin
          ch = (it.text_byte >= "A" && it.text_byte <= "Z") ? it.text_byte + 8'd32
                                                            : it.text_byte;
          if (word_len < WORD_SLOTS) begin
            word_buf[word_len] = ch;
            word_len++;
          end else begin
            word_long = 1'b1;
          end
        end
      end
      KIND_END: close_word();
      KIND_EMIT: begin
        close_word();
        for (int c = 0; c < CATS; c++) begin
          r.category     = c[3:0];
          r.score_tenths = cat_score[c];
          r.touched      = cat_hit[c];
          r.last         = (c == CATS - 1);
          queue_result(r);
        end
        foreach (word_buf[i]) word_buf[i] = 8'h00;
        foreach (cat_score[c]) begin
          cat_score[c] = 4'd0;
          cat_hit[c]   = 1'b0;
        end
      end
      default: ;   // ignored kind
    endcase
  endtask

  // one input beat: present it, wait for the handshake, then maybe go idle
  task automatic send_beat(item_t it, bit typed, logic [47:0] t_score, logic [11:0] t_hit);
    result_t r;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    track_beat(it);
    if (it.kind != KIND_IGNORED) fed++;
    if (typed) begin
      // swap the computed emit for the hand-written one
      repeat (CATS) r = due_results.pop_back();
      for (int c = 0; c < CATS; c++) begin
        r.category     = c[3:0];
        r.score_tenths = t_score[4*c +: 4];
        r.touched      = t_hit[c];
        r.last         = (c == CATS - 1);
        queue_result(r);
      end
    end
    if ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
  endtask

  // text bytes, in noisy mode with an occasional ignored beat mixed in
  task automatic send_text(string s, bit noisy);
    item_t it;
    for (int i = 0; i < s.len(); i++) begin
      if (noisy && $urandom_range(99) < 3) begin
        it.kind      = KIND_IGNORED;
        it.text_byte = $urandom_range(255);
        send_beat(it, 1'b0, '0, '0);
      end
      it.kind      = KIND_BYTE;
      it.text_byte = s[i];
      send_beat(it, 1'b0, '0, '0);
    end
  endtask

  // hold the sender off until every pending result beat is out
  task automatic settle();
    item_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(61);
    if (r < 10) return 8'(r) + "0";
    if (r < 36) return 8'(r - 10) + "A";
    return 8'(r - 36) + "a";
  endfunction

  // mostly keywords, plus near misses, random tokens that may overflow, and empties
  function automatic string random_word();
    string s;
    int    pick;
    int    n;
    pick = $urandom_range(99);
    if (pick < 65) begin
      s = kw_word[$urandom_range(WORDS - 1)];
    end else if (pick < 80) begin
      n = $urandom_range(1, 20);
      s = "xxxxxxxxxxxxxxxxxxxx";
      s = s.substr(0, n - 1);
      for (int i = 0; i < n; i++) s[i] = word_char();
    end else if (pick < 90) begin
      s = kw_word[$urandom_range(WORDS - 1)];
      case ($urandom_range(2))
        0: begin
          s = {s, "x"};
          s[s.len() - 1] = word_char();
        end
        1: begin
          s = {"x", s};
          s[0] = word_char();
        end
        default: s = s.substr(0, s.len() - 2);
      endcase
    end else begin
      s = "";
    end
    for (int i = 0; i < s.len(); i++)
      if (s[i] >= "a" && s[i] <= "z" && $urandom_range(3) == 0) s[i] = s[i] - 8'd32;
    return s;
  endfunction

  task automatic send_separator();
    item_t it;
    if ($urandom_range(99) < 85) begin
      it.kind = KIND_BYTE;
      do it.text_byte = $urandom_range(255); while (is_word_char(it.text_byte));
    end else begin
      it.kind      = KIND_END;
      it.text_byte = $urandom_range(255);
    end
    send_beat(it, 1'b0, '0, '0);
  endtask

  // one profile: a few texts of random tokens, the last closed by an emit
  task automatic random_profile();
    item_t closing;
    int    n_texts;
    int    n_tokens;
    n_texts = $urandom_range(1, 3);
    for (int t = 0; t < n_texts; t++) begin
      n_tokens = $urandom_range(0, 6);
      for (int w = 0; w < n_tokens; w++) begin
        send_text(random_word(), 1'b1);
        // the last token may be left for the closing beat to end
        if (w < n_tokens - 1 || $urandom_range(1) == 1) send_separator();
      end
      closing.kind      = (t == n_texts - 1) ? KIND_EMIT : KIND_END;
      closing.text_byte = $urandom_range(255);
      send_beat(closing, 1'b0, '0, '0);
    end
    // now and then let the result side drain completely
    if ($urandom_range(4) == 0) settle();
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checker: every accepted beat against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat cat %0d score %0d touched %0b last %0b",
                   $realtime, result.category, result.score_tenths, result.touched,
                   result.last);
      end else begin
        want = due_results.pop_front();
        if (result.category !== want.category || result.score_tenths !== want.score_tenths ||
            result.touched !== want.touched || result.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch want cat %0d score %0d touched %0b last %0b, got cat %0d score %0d touched %0b last %0b",
                     $realtime, want.category, want.score_tenths, want.touched, want.last,
                     result.category, result.score_tenths, result.touched, result.last);
        end
      end
    end
  end

  initial begin
    item_t closing;
    foreach (word_buf[i]) word_buf[i] = 8'h00;
    foreach (cat_score[c]) begin
      cat_score[c] = 4'd0;
      cat_hit[c]   = 1'b0;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed script, sender sparse idle, receiver mostly stalled
    foreach (script[r]) begin
      send_text(script[r].text, 1'b0);
      closing.kind      = script[r].close_kind;
      closing.text_byte = script[r].close_byte;
      send_beat(closing, script[r].typed, script[r].typed_score, script[r].typed_hit);
    end

    fed = 0;
    while (fed < 85) random_profile();
    settle();

    // sender mostly idle, receiver rarely stalls
    gap_pct   = 85;
    stall_pct = 9;
    while (fed < 170) random_profile();
    settle();

    // full rate both ways
    gap_pct   = 0;
    stall_pct = 0;
    while (fed < 250) random_profile();
    settle();

    // leave room for stray result beats before the verdict
    repeat (32) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
